/* rtl/segx_pkg.sv */
// Package for the segment intersection core: widths, transfer structs and helpers.
// Used by rtl/segment_intersection_core.sv; depends on nothing else.
package segx_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int TOL_BITS   = 16;

  // Coordinate difference, product, cross product and wide numerator widths
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int CW = PW + 1;
  localparam int NW = CW + COORD_BITS;
  // Split of the normalized t numerator for the second multiply
  localparam int HI_BITS = CW / 2;
  localparam int LO_BITS = CW - HI_BITS;
  // Quotient bits: |t*dA| never exceeds |dA| < 2**COORD_BITS
  localparam int QB = COORD_BITS;

  // Register byte addresses
  localparam logic [2:0] ADDR_TOLERANCE = 3'd0;
  localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(1);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_start_x;
    logic signed [COORD_BITS-1:0] a_start_y;
    logic signed [COORD_BITS-1:0] a_end_x;
    logic signed [COORD_BITS-1:0] a_end_y;
    logic signed [COORD_BITS-1:0] b_start_x;
    logic signed [COORD_BITS-1:0] b_start_y;
    logic signed [COORD_BITS-1:0] b_end_x;
    logic signed [COORD_BITS-1:0] b_end_y;
  } seg_in_t;

  typedef struct packed {
    logic                         hit;
    logic signed [COORD_BITS-1:0] cross_x;
    logic signed [COORD_BITS-1:0] cross_y;
  } seg_out_t;

  // Difference of two coordinates at full precision
  function automatic logic signed [DW-1:0] diff(logic signed [COORD_BITS-1:0] a,
                                                logic signed [COORD_BITS-1:0] b);
    logic signed [DW-1:0] ea;
    logic signed [DW-1:0] eb;
    ea = {a[COORD_BITS-1], a};
    eb = {b[COORD_BITS-1], b};
    return ea - eb;
  endfunction

  // Magnitude of a difference; always fits COORD_BITS
  function automatic logic [COORD_BITS-1:0] mag(logic signed [DW-1:0] v);
    logic [DW-1:0] n;
    n = v[DW-1] ? DW'(-v) : DW'(v);
    return n[COORD_BITS-1:0];
  endfunction

endpackage

/* rtl/segment_intersection_core.sv */
// Two-segment intersection core: a 40-stage pipeline with a bit-per-stage divider.
// Depends on rtl/segx_pkg.sv.
// Throughput: one segment pair per cycle unless stalled; the 32-stage restoring divider sets the depth.
// Stall: a stalled result holds the whole pipeline, in_stall_o follows it.
// Reset: all valid bits clear, tolerance returns to 1; no clearing pass.
module segment_intersection_core
  import segx_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  seg_in_t         in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output seg_out_t        out_data_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  logic [TOL_BITS-1:0] tol_q;
  logic                en;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_TOLERANCE) ? 32'(tol_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_TOLERANCE) begin
      tol_q <= pwdata[TOL_BITS-1:0];
    end
  end

  // Global advance: move when the output register is free or being taken
  logic out_v_q;
  assign en          = !out_v_q || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = out_v_q;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  // Stage 1: differences, magnitudes and special-case flags
  logic signed [DW-1:0] s1x_q, s1y_q, s2x_q, s2y_q, dx_q, dy_q;
  logic signed [DW-1:0] s1y_w, s2y_w;
  logic [COORD_BITS-1:0] ax1_q, ay1_q, by1_q;
  logic [COORD_BITS-1:0] mx1_q, my1_q;
  logic nx1_q, ny1_q, hz1_q, vh1_q;

  assign s1y_w = diff(in_data_i.a_end_y, in_data_i.a_start_y);
  assign s2y_w = diff(in_data_i.b_end_y, in_data_i.b_start_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1x_q <= diff(in_data_i.a_end_x, in_data_i.a_start_x);
      s1y_q <= s1y_w;
      s2x_q <= diff(in_data_i.b_end_x, in_data_i.b_start_x);
      s2y_q <= s2y_w;
      dx_q  <= diff(in_data_i.a_start_x, in_data_i.b_start_x);
      dy_q  <= diff(in_data_i.a_start_y, in_data_i.b_start_y);
      ax1_q <= in_data_i.a_start_x;
      ay1_q <= in_data_i.a_start_y;
      by1_q <= in_data_i.b_start_y;
      mx1_q <= mag(diff(in_data_i.a_end_x, in_data_i.a_start_x));
      my1_q <= mag(s1y_w);
      nx1_q <= (in_data_i.a_start_x > in_data_i.a_end_x);
      ny1_q <= s1y_w[DW-1];
      hz1_q <= (mag(s1y_w) < COORD_BITS'(tol_q)) && (mag(s2y_w) < COORD_BITS'(tol_q));
      vh1_q <= (in_data_i.a_start_x == in_data_i.a_end_x) &&
               (in_data_i.b_start_y == in_data_i.b_end_y);
    end
  end

  // Stage 2: six cross-product terms
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic [COORD_BITS-1:0] ax2_q, ay2_q, by2_q, mx2_q, my2_q;
  logic nx2_q, ny2_q, hz2_q, vh2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q  <= s1x_q * s2y_q;
      p1_q  <= s2x_q * s1y_q;
      p2_q  <= s1x_q * dy_q;
      p3_q  <= s1y_q * dx_q;
      p4_q  <= s2x_q * dy_q;
      p5_q  <= s2y_q * dx_q;
      ax2_q <= ax1_q;
      ay2_q <= ay1_q;
      by2_q <= by1_q;
      mx2_q <= mx1_q;
      my2_q <= my1_q;
      nx2_q <= nx1_q;
      ny2_q <= ny1_q;
      hz2_q <= hz1_q;
      vh2_q <= vh1_q;
    end
  end

  // Stage 3: denominator and both numerators
  logic signed [CW-1:0] den3_q, sn3_q, tn3_q;
  logic [COORD_BITS-1:0] ax3_q, ay3_q, by3_q, mx3_q, my3_q;
  logic nx3_q, ny3_q, hz3_q, vh3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      den3_q <= CW'(p0_q) - CW'(p1_q);
      sn3_q  <= CW'(p2_q) - CW'(p3_q);
      tn3_q  <= CW'(p4_q) - CW'(p5_q);
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
      by3_q  <= by2_q;
      mx3_q  <= mx2_q;
      my3_q  <= my2_q;
      nx3_q  <= nx2_q;
      ny3_q  <= ny2_q;
      hz3_q  <= hz2_q;
      vh3_q  <= vh2_q;
    end
  end

  // Stage 4: make the denominator positive
  logic [CW-1:0] den4_q, sn4_q, tn4_q;
  logic [COORD_BITS-1:0] ax4_q, ay4_q, by4_q, mx4_q, my4_q;
  logic nx4_q, ny4_q, hz4_q, vh4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      den4_q <= den3_q[CW-1] ? CW'(-den3_q) : CW'(den3_q);
      sn4_q  <= den3_q[CW-1] ? CW'(-sn3_q)  : CW'(sn3_q);
      tn4_q  <= den3_q[CW-1] ? CW'(-tn3_q)  : CW'(tn3_q);
      ax4_q  <= ax3_q;
      ay4_q  <= ay3_q;
      by4_q  <= by3_q;
      mx4_q  <= mx3_q;
      my4_q  <= my3_q;
      nx4_q  <= nx3_q;
      ny4_q  <= ny3_q;
      hz4_q  <= hz3_q;
      vh4_q  <= vh3_q;
    end
  end

  // Stage 5: tolerance and parameter range tests
  logic [CW-1:0] tolw;
  logic [CW-1:0] den5_q, tn5_q;
  logic [COORD_BITS-1:0] ax5_q, ay5_q, by5_q, mx5_q, my5_q;
  logic nx5_q, ny5_q, hit5_q, vh5_q;

  assign tolw = CW'(tol_q) << FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit5_q <= !hz4_q && !(den4_q < tolw) && (den4_q != '0) &&
                !sn4_q[CW-1] && !(sn4_q > den4_q) &&
                !tn4_q[CW-1] && !(tn4_q > den4_q);
      den5_q <= den4_q;
      tn5_q  <= tn4_q;
      ax5_q  <= ax4_q;
      ay5_q  <= ay4_q;
      by5_q  <= by4_q;
      mx5_q  <= mx4_q;
      my5_q  <= my4_q;
      nx5_q  <= nx4_q;
      ny5_q  <= ny4_q;
      vh5_q  <= vh4_q;
    end
  end

  // Stage 6: partial products of t numerator and segment A extent
  logic [LO_BITS+COORD_BITS-1:0] plx_q, ply_q;
  logic [HI_BITS+COORD_BITS-1:0] phx_q, phy_q;
  logic [CW-1:0] den6_q;
  logic [COORD_BITS-1:0] ax6_q, ay6_q, by6_q;
  logic nx6_q, ny6_q, hit6_q, vh6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      plx_q  <= tn5_q[LO_BITS-1:0] * mx5_q;
      phx_q  <= tn5_q[CW-1:LO_BITS] * mx5_q;
      ply_q  <= tn5_q[LO_BITS-1:0] * my5_q;
      phy_q  <= tn5_q[CW-1:LO_BITS] * my5_q;
      den6_q <= den5_q;
      ax6_q  <= ax5_q;
      ay6_q  <= ay5_q;
      by6_q  <= by5_q;
      nx6_q  <= nx5_q;
      ny6_q  <= ny5_q;
      hit6_q <= hit5_q;
      vh6_q  <= vh5_q;
    end
  end

  // Divider pipeline; index 0 is loaded with the combined numerators
  logic                  dv_q  [0:QB];
  logic [NW-1:0]         rx_q  [0:QB];
  logic [NW-1:0]         ry_q  [0:QB];
  logic [QB-1:0]         qx_q  [0:QB];
  logic [QB-1:0]         qy_q  [0:QB];
  logic [CW-1:0]         dd_q  [0:QB];
  logic [COORD_BITS-1:0] dax_q [0:QB];
  logic [COORD_BITS-1:0] day_q [0:QB];
  logic [COORD_BITS-1:0] dby_q [0:QB];
  logic                  dnx_q [0:QB];
  logic                  dny_q [0:QB];
  logic                  dhit_q[0:QB];
  logic                  dvh_q [0:QB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q[0]   <= NW'(plx_q) + (NW'(phx_q) << LO_BITS);
      ry_q[0]   <= NW'(ply_q) + (NW'(phy_q) << LO_BITS);
      qx_q[0]   <= '0;
      qy_q[0]   <= '0;
      dd_q[0]   <= den6_q;
      dax_q[0]  <= ax6_q;
      day_q[0]  <= ay6_q;
      dby_q[0]  <= by6_q;
      dnx_q[0]  <= nx6_q;
      dny_q[0]  <= ny6_q;
      dhit_q[0] <= hit6_q;
      dvh_q[0]  <= vh6_q;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 1; k <= QB; k++) begin : g_div
    logic [NW-1:0] trial;
    logic          gex, gey;

    assign trial = NW'(dd_q[k-1]) << (QB - k);
    assign gex   = rx_q[k-1] >= trial;
    assign gey   = ry_q[k-1] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (en) begin
        dv_q[k] <= dv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rx_q[k]   <= gex ? rx_q[k-1] - trial : rx_q[k-1];
        ry_q[k]   <= gey ? ry_q[k-1] - trial : ry_q[k-1];
        qx_q[k]   <= qx_q[k-1] | (QB'(gex) << (QB - k));
        qy_q[k]   <= qy_q[k-1] | (QB'(gey) << (QB - k));
        dd_q[k]   <= dd_q[k-1];
        dax_q[k]  <= dax_q[k-1];
        day_q[k]  <= day_q[k-1];
        dby_q[k]  <= dby_q[k-1];
        dnx_q[k]  <= dnx_q[k-1];
        dny_q[k]  <= dny_q[k-1];
        dhit_q[k] <= dhit_q[k-1];
        dvh_q[k]  <= dvh_q[k-1];
      end
    end
  end

  // Output register: apply signs, add start point (A vertical, B horizontal: take A's x, B's y), mask misses
  logic [COORD_BITS-1:0] offx, offy, px, py;
  seg_out_t              out_d;
  seg_out_t              out_q;

  assign offx = dnx_q[QB] ? COORD_BITS'(-qx_q[QB]) : qx_q[QB];
  assign offy = dny_q[QB] ? COORD_BITS'(-qy_q[QB]) : qy_q[QB];
  assign px   = dvh_q[QB] ? dax_q[QB] : dax_q[QB] + offx;
  assign py   = dvh_q[QB] ? dby_q[QB] : day_q[QB] + offy;

  always_comb begin
    out_d.hit     = dhit_q[QB];
    out_d.cross_x = dhit_q[QB] ? px : '0;
    out_d.cross_y = dhit_q[QB] ? py : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule
